@@ rtl/core/dstq_pkg.sv @@
// shared types, codes and helpers for the deadline sorted timer queue
// no dependencies
`default_nettype none

package dstq_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int ID_BITS_DEF  = 16;
    localparam int TIME_W       = 63;
    localparam int DELTA_W      = 64;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_CANCEL = 2'd2,
        CMD_ADJUST = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOT_DUE = 2'd1,
        ST_NO_ID   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd                cmd;
        logic [TIME_W-1:0]   now;
        logic [TIME_W-1:0]   due;
        logic [DELTA_W-1:0]  delta;
    } t_work;

    // due minus signed delta, clamped to 0 .. TIME_MAX
    function automatic logic [TIME_W-1:0] adjust_due(
        input logic [TIME_W-1:0]  due,
        input logic [DELTA_W-1:0] delta
    );
        logic [DELTA_W+1:0] s;
        begin
            s = {3'b000, due} - {{2{delta[DELTA_W-1]}}, delta};
            if (s[DELTA_W+1]) begin
                adjust_due = '0;
            end else if (s[DELTA_W:TIME_W] != 2'b00) begin
                adjust_due = TIME_MAX;
            end else begin
                adjust_due = s[TIME_W-1:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/deadline_sorted_timer_queue.sv @@
// top level of the deadline sorted timer queue
// depends on dstq_pkg, dstq_front, dstq_back
`default_nettype none

// Holds up to CAPACITY timers (id plus 63-bit due time) in a sorted cell
// array, head at cell 0, ties in arrival order. Commands: 0 enqueue,
// 1 dequeue if due, 2 cancel by id, 3 adjust all due times by a signed delta
// with saturation. Every command gives exactly one result word. A two-word
// input queue decouples the front end from the cell array, which works through
// each command in order: it compares every cell against the word, shifts or
// updates the cells, then forms the head remaining time into the output
// register. The array takes no new command until the last one is reported,
// and waits longer while the output register is held by the consumer.
module deadline_sorted_timer_queue #(
    parameter int CAPACITY = dstq_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = dstq_pkg::ID_BITS_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_command,
    input  wire logic [dstq_pkg::TIME_W-1:0]   i_now_time,
    input  wire logic [ID_BITS-1:0]            i_timer_id,
    input  wire logic [dstq_pkg::TIME_W-1:0]   i_due_time,
    input  wire logic [dstq_pkg::DELTA_W-1:0]  i_adjust_delta,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [1:0]                         o_status,
    output logic [ID_BITS-1:0]                 o_out_id,
    output logic [dstq_pkg::TIME_W-1:0]        o_out_due,
    output logic                               o_notify,
    output logic                               o_head_valid,
    output logic [dstq_pkg::DELTA_W-1:0]       o_head_remaining,
    output logic [CNT_W-1:0]                   o_entry_count
);
    import dstq_pkg::*;

    logic               w_work_valid, w_work_ready;
    t_work              w_work;
    logic [ID_BITS-1:0] w_work_id;

    dstq_front #(
        .ID_BITS(ID_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_now_time     (i_now_time),
        .i_timer_id     (i_timer_id),
        .i_due_time     (i_due_time),
        .i_adjust_delta (i_adjust_delta),
        .o_work_valid   (w_work_valid),
        .i_work_ready   (w_work_ready),
        .o_work         (w_work),
        .o_work_id      (w_work_id)
    );

    dstq_back #(
        .CAPACITY(CAPACITY),
        .ID_BITS (ID_BITS),
        .CNT_W   (CNT_W)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_work_valid     (w_work_valid),
        .o_work_ready     (w_work_ready),
        .i_work           (w_work),
        .i_work_id        (w_work_id),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_out_id         (o_out_id),
        .o_out_due        (o_out_due),
        .o_notify         (o_notify),
        .o_head_valid     (o_head_valid),
        .o_head_remaining (o_head_remaining),
        .o_entry_count    (o_entry_count)
    );

endmodule

`default_nettype wire

@@ rtl/core/dstq_front.sv @@
// front end: takes input words, packs them into work words and queues them
// depends on dstq_pkg
`default_nettype none

module dstq_front #(
    parameter int ID_BITS = dstq_pkg::ID_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_command,
    input  wire logic [dstq_pkg::TIME_W-1:0]   i_now_time,
    input  wire logic [ID_BITS-1:0]            i_timer_id,
    input  wire logic [dstq_pkg::TIME_W-1:0]   i_due_time,
    input  wire logic [dstq_pkg::DELTA_W-1:0]  i_adjust_delta,
    output logic                               o_work_valid,
    input  wire logic                          i_work_ready,
    output dstq_pkg::t_work                    o_work,
    output logic [ID_BITS-1:0]                 o_work_id
);
    import dstq_pkg::*;

    t_work             r_q  [2];
    logic [ID_BITS-1:0] r_qid [2];
    logic              r_wr, r_rd;
    logic [1:0]        r_cnt;
    t_work             w_in;
    logic              w_push, w_pop;

    always_comb begin
        w_in.now   = i_now_time;
        w_in.due   = i_due_time;
        w_in.delta = i_adjust_delta;
        w_in.cmd   = t_cmd'(i_command);
    end

    assign o_ready      = (r_cnt != 2'd2);
    assign o_work_valid = (r_cnt != 2'd0);
    assign o_work       = r_q[r_rd];
    assign o_work_id    = r_qid[r_rd];
    assign w_push       = i_valid && o_ready;
    assign w_pop        = o_work_valid && i_work_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr]   <= w_in;
            r_qid[r_wr] <= i_timer_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/dstq_back.sv @@
// back end: sorted cell array that executes commands and holds the result word
// depends on dstq_pkg
`default_nettype none

module dstq_back #(
    parameter int CAPACITY = dstq_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = dstq_pkg::ID_BITS_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_work_valid,
    output logic                               o_work_ready,
    input  wire dstq_pkg::t_work               i_work,
    input  wire logic [ID_BITS-1:0]            i_work_id,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [1:0]                         o_status,
    output logic [ID_BITS-1:0]                 o_out_id,
    output logic [dstq_pkg::TIME_W-1:0]        o_out_due,
    output logic                               o_notify,
    output logic                               o_head_valid,
    output logic [dstq_pkg::DELTA_W-1:0]       o_head_remaining,
    output logic [CNT_W-1:0]                   o_entry_count
);
    import dstq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_APPLY  = 3'b010,
        S_REPORT = 3'b100
    } t_state;

    t_state              r_state;
    t_work               r_cur;
    logic [ID_BITS-1:0]  r_cur_id;
    logic [CNT_W-1:0]    r_count;
    logic [TIME_W-1:0]   r_due [CAPACITY];
    logic [ID_BITS-1:0]  r_id  [CAPACITY];
    logic [CAPACITY-1:0] r_le, r_ge;
    logic                r_found;
    t_status             r_status;
    logic [ID_BITS-1:0]  r_oid;
    logic [TIME_W-1:0]   r_odue;
    logic                r_notify;

    t_status             n_status;
    logic [ID_BITS-1:0]  n_oid;
    logic [TIME_W-1:0]   n_odue;
    logic                n_notify;

    logic [CAPACITY-1:0] w_valid, w_le, w_match, w_first;
    logic                w_take;
    logic                w_do_ins, w_do_deq, w_do_rm, w_do_adj;
    logic                w_full, w_deq_ok;

    assign o_work_ready = (r_state == S_IDLE);
    assign w_take       = i_work_valid && o_work_ready;

    // per-cell compares against the incoming word
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cmp
        assign w_valid[k] = (CNT_W'(k) < r_count);
        assign w_le[k]    = w_valid[k] && (r_due[k] <= i_work.due);
        assign w_match[k] = w_valid[k] && (r_id[k] == i_work_id);
    end
    // isolate first match from the head
    assign w_first = w_match & (~w_match + CAPACITY'(1));

    assign w_full   = (r_count >= CNT_W'(CAPACITY));
    assign w_deq_ok = (r_count != '0) && !(r_cur.now < r_due[0]);
    assign w_do_ins = (r_state == S_APPLY) && (r_cur.cmd == CMD_ENQ) && !w_full;
    assign w_do_deq = (r_state == S_APPLY) && (r_cur.cmd == CMD_DEQ) && w_deq_ok;
    assign w_do_rm  = (r_state == S_APPLY) && (r_cur.cmd == CMD_CANCEL) && r_found;
    assign w_do_adj = (r_state == S_APPLY) && (r_cur.cmd == CMD_ADJUST);

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [TIME_W-1:0]  w_up_due, w_dn_due;
        logic [ID_BITS-1:0] w_up_id, w_dn_id;
        logic               w_lo_le;
        if (k < CAPACITY - 1) begin : g_up
            assign w_up_due = r_due[k+1];
            assign w_up_id  = r_id[k+1];
        end else begin : g_top
            assign w_up_due = r_due[k];
            assign w_up_id  = r_id[k];
        end
        if (k > 0) begin : g_dn
            assign w_dn_due = r_due[k-1];
            assign w_dn_id  = r_id[k-1];
            assign w_lo_le  = r_le[k-1];
        end else begin : g_head
            assign w_dn_due = r_due[k];
            assign w_dn_id  = r_id[k];
            assign w_lo_le  = 1'b1;
        end

        always_ff @(posedge i_clk) begin
            if (w_do_ins && !r_le[k]) begin
                if (w_lo_le) begin
                    r_due[k] <= r_cur.due;
                    r_id[k]  <= r_cur_id;
                end else begin
                    r_due[k] <= w_dn_due;
                    r_id[k]  <= w_dn_id;
                end
            end else if (w_do_deq || (w_do_rm && r_ge[k])) begin
                r_due[k] <= w_up_due;
                r_id[k]  <= w_up_id;
            end else if (w_do_adj) begin
                r_due[k] <= adjust_due(r_due[k], r_cur.delta);
            end
        end
    end

    always_comb begin
        n_status = ST_OK;
        n_oid    = '0;
        n_odue   = '0;
        n_notify = 1'b0;
        unique case (r_cur.cmd)
            CMD_ENQ: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_notify = !r_le[0];
                end
            end
            CMD_DEQ: begin
                if (!w_deq_ok) begin
                    n_status = ST_NOT_DUE;
                end else begin
                    n_oid  = r_id[0];
                    n_odue = r_due[0];
                end
            end
            CMD_CANCEL: begin
                if (!r_found) begin
                    n_status = ST_NO_ID;
                end else begin
                    n_notify = r_ge[0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cur    <= i_work;
            r_cur_id <= i_work_id;
            r_le     <= w_le;
            r_ge     <= ~(w_first - CAPACITY'(1));
            r_found  <= |w_match;
        end
        if (r_state == S_APPLY) begin
            r_status <= n_status;
            r_oid    <= n_oid;
            r_odue   <= n_odue;
            r_notify <= n_notify;
        end
        if ((r_state == S_REPORT) && (!o_valid || i_ready)) begin
            o_status      <= r_status;
            o_out_id      <= r_oid;
            o_out_due     <= r_odue;
            o_notify      <= r_notify;
            o_head_valid  <= (r_count != '0);
            o_entry_count <= r_count;
            o_head_remaining <= (r_count != '0)
                ? ({1'b0, r_due[0]} - {1'b0, r_cur.now}) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            if (w_do_ins) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_do_deq || w_do_rm) begin
                r_count <= r_count - CNT_W'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_state <= S_REPORT;
                end
                S_REPORT: begin
                    if (!o_valid || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if ((r_state == S_REPORT) && (!o_valid || i_ready)) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("timer count above capacity");
    a_enq_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_ins |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow count");
    a_notify_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_notify) |-> (o_status == ST_OK))
        else $error("notify on failed command");
    a_head_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_head_valid == (o_entry_count != '0)))
        else $error("head flag disagrees with count");
`endif

endmodule

`default_nettype wire
